>>> sv/rgb_pkg.sv
package rgb_pkg;

  localparam int MAX_AGES_DEF  = 32;
  localparam int MAX_TIMES_DEF = 32;
  localparam int MAX_ROWS_DEF  = 1024;

  localparam int ID_W    = 16;
  localparam int WGT_W   = 64;
  localparam int IDX_W   = 5;
  localparam int CNT_W   = 6;
  localparam int OCC_W   = 11;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_COUNT = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;     // capture the accepted item
    logic exec;      // perform clear, load or the query setup
    logic scan;      // issue one row store read
    logic load_out;  // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_needed;  // a valid query over a nonempty row store
    logic scan_last;    // the current scan address is the last stored row
    logic out_free;     // the output register can take a result
  } sts_t;

endpackage

>>> sv/rgb_set.sv
module rgb_set #(
  parameter int DEPTH = rgb_pkg::MAX_AGES_DEF,
  localparam int SW = $clog2(DEPTH + 1),
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic                       ins,
  input  logic [rgb_pkg::ID_W-1:0]   v,
  input  logic [rgb_pkg::IDX_W-1:0]  idx,
  output logic [SW-1:0]              size,
  output logic                       blocked,
  output logic                       in_range,
  output logic [rgb_pkg::ID_W-1:0]   rd_data
);

  logic [rgb_pkg::ID_W-1:0] entry [DEPTH];
  logic [DEPTH-1:0] lt;
  logic [DEPTH-1:0] eq;
  logic exists;
  logic [IW-1:0] ridx;

  // Entries are kept sorted, so the entries below v form a prefix.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cmp
    localparam logic [SW-1:0] KI = SW'(k);
    assign lt[k] = (KI < size) && (entry[k] < v);
    assign eq[k] = (KI < size) && (entry[k] == v);
  end

  assign exists   = |eq;
  assign blocked  = (size >= SW'(DEPTH)) && !exists;
  assign ridx     = IW'(idx);
  assign in_range = 32'(idx) < 32'(size);
  assign rd_data  = entry[ridx];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      size <= '0;
    end else if (ins && !exists && (size < SW'(DEPTH))) begin
      size <= size + SW'(1);
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_ent
    localparam logic [SW-1:0] KI = SW'(k);
    logic put;
    logic shift;
    if (k == 0) begin : g_first
      assign put   = !lt[k];
      assign shift = 1'b0;
    end else begin : g_rest
      assign put   = !lt[k] && lt[k-1] && (KI <= size);
      assign shift = !lt[k-1] && (KI <= size);
    end
    always_ff @(posedge clk) begin
      if (ins && !clear && !exists && (size < SW'(DEPTH))) begin
        if (put) begin
          entry[k] <= v;
        end else if (shift) begin
          if (k > 0) begin
            entry[k] <= entry[(k > 0) ? k - 1 : 0];
          end
        end
      end
    end
  end

endmodule

>>> sv/rgb_ctrl.sv
module rgb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rgb_pkg::sts_t sts,
  output rgb_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready     = (state == S_IDLE);
  assign cmd.latch    = (state == S_IDLE) && in_valid;
  assign cmd.exec     = (state == S_EXEC);
  assign cmd.scan     = (state == S_SCAN);
  assign cmd.load_out = (state == S_FINISH) && sts.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_EXEC;
      S_EXEC:   state_next = sts.scan_needed ? S_SCAN : S_FINISH;
      S_SCAN:   if (sts.scan_last) state_next = S_DRAIN;
      S_DRAIN:  state_next = S_FINISH;
      S_FINISH: if (sts.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> sv/rgb_dp.sv
module rgb_dp #(
  parameter int MAX_AGES  = rgb_pkg::MAX_AGES_DEF,
  parameter int MAX_TIMES = rgb_pkg::MAX_TIMES_DEF,
  parameter int MAX_ROWS  = rgb_pkg::MAX_ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rgb_pkg::cmd_t               cmd,
  output rgb_pkg::sts_t               sts,
  input  logic                        selected_weight_id_we,
  input  logic [rgb_pkg::ID_W-1:0]    selected_weight_id,
  input  logic [1:0]                  operation,
  input  logic [rgb_pkg::ID_W-1:0]    row_weight_id,
  input  logic [rgb_pkg::ID_W-1:0]    row_age_id,
  input  logic [rgb_pkg::ID_W-1:0]    row_time_id,
  input  logic [rgb_pkg::WGT_W-1:0]   row_weight,
  input  logic [rgb_pkg::IDX_W-1:0]   age_index,
  input  logic [rgb_pkg::IDX_W-1:0]   time_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [rgb_pkg::CNT_W-1:0]   age_count,
  output logic [rgb_pkg::CNT_W-1:0]   time_count,
  output logic [rgb_pkg::ID_W-1:0]    cell_age_id,
  output logic [rgb_pkg::ID_W-1:0]    cell_time_id,
  output logic [rgb_pkg::WGT_W-1:0]   cell_weight,
  output logic [rgb_pkg::OCC_W-1:0]   occurrences
);

  localparam int AS_W = $clog2(MAX_AGES + 1);
  localparam int TS_W = $clog2(MAX_TIMES + 1);
  localparam int RW   = $clog2(MAX_ROWS + 1);
  localparam int AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  typedef struct packed {
    logic [rgb_pkg::ID_W-1:0]  age;
    logic [rgb_pkg::ID_W-1:0]  tim;
    logic [rgb_pkg::WGT_W-1:0] wgt;
  } row_t;

  logic [rgb_pkg::ID_W-1:0]  sel;
  logic [1:0]                op;
  logic [rgb_pkg::ID_W-1:0]  wid;
  logic [rgb_pkg::ID_W-1:0]  aid;
  logic [rgb_pkg::ID_W-1:0]  tid;
  logic [rgb_pkg::WGT_W-1:0] wgt;
  logic [rgb_pkg::IDX_W-1:0] ai;
  logic [rgb_pkg::IDX_W-1:0] ti;

  logic [AS_W-1:0] a_size;
  logic [TS_W-1:0] t_size;
  logic a_blocked, t_blocked, a_in, t_in;
  logic [rgb_pkg::ID_W-1:0] a_rd, t_rd;

  row_t mem [MAX_ROWS];
  row_t rd;
  logic rd_v;
  logic [RW-1:0] row_size;
  logic [AW-1:0] scan_addr;

  logic [1:0] st;
  logic qv;
  logic [rgb_pkg::ID_W-1:0] qa, qt;
  logic [RW-1:0] occ;
  logic [rgb_pkg::WGT_W-1:0] cw;

  logic is_clear, is_load, is_query, match, full, do_store, query_ok;

  assign is_clear = (op == rgb_pkg::OP_CLEAR);
  assign is_load  = (op == rgb_pkg::OP_LOAD);
  assign is_query = (op == rgb_pkg::OP_QUERY);
  assign match    = (wid == sel);
  assign full     = (row_size >= RW'(MAX_ROWS)) || a_blocked || t_blocked;
  assign do_store = cmd.exec && is_load && match && !full;
  assign query_ok = a_in && t_in;

  assign sts.scan_needed = is_query && query_ok && (row_size != '0);
  assign sts.scan_last   = (RW'(scan_addr) + RW'(1)) == row_size;
  assign sts.out_free    = !out_valid || out_ready;

  rgb_set #(.DEPTH(MAX_AGES)) u_age_set (
    .clk(clk), .rst(rst), .clear(cmd.exec && is_clear), .ins(do_store), .v(aid),
    .idx(ai), .size(a_size), .blocked(a_blocked), .in_range(a_in), .rd_data(a_rd)
  );

  rgb_set #(.DEPTH(MAX_TIMES)) u_time_set (
    .clk(clk), .rst(rst), .clear(cmd.exec && is_clear), .ins(do_store), .v(tid),
    .idx(ti), .size(t_size), .blocked(t_blocked), .in_range(t_in), .rd_data(t_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= '0;
    end else if (selected_weight_id_we) begin
      sel <= selected_weight_id;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op  <= operation;
      wid <= row_weight_id;
      aid <= row_age_id;
      tid <= row_time_id;
      wgt <= row_weight;
      ai  <= age_index;
      ti  <= time_index;
    end
  end

  // Row store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (do_store) begin
      mem[row_size[AW-1:0]] <= '{age: aid, tim: tid, wgt: wgt};
    end
    if (cmd.scan) begin
      rd <= mem[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_size <= '0;
      rd_v     <= 1'b0;
    end else begin
      rd_v <= cmd.scan;
      if (cmd.exec && is_clear) begin
        row_size <= '0;
      end else if (do_store) begin
        row_size <= row_size + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      scan_addr <= '0;
      occ       <= '0;
      cw        <= '0;
      qa        <= a_rd;
      qt        <= t_rd;
      qv        <= is_query && query_ok;
      if (is_query && !query_ok) begin
        st <= rgb_pkg::ST_RANGE;
      end else if (is_load && match && full) begin
        st <= rgb_pkg::ST_FULL;
      end else begin
        st <= rgb_pkg::ST_OK;
      end
    end else begin
      if (cmd.scan) begin
        scan_addr <= scan_addr + AW'(1);
      end
      if (rd_v && (rd.age == qa) && (rd.tim == qt)) begin
        occ <= occ + RW'(1);
        cw  <= rd.wgt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status       <= (qv && (occ != RW'(1))) ? rgb_pkg::ST_COUNT : st;
      age_count    <= rgb_pkg::CNT_W'(a_size);
      time_count   <= rgb_pkg::CNT_W'(t_size);
      cell_age_id  <= qv ? qa : '0;
      cell_time_id <= qv ? qt : '0;
      cell_weight  <= cw;
      occurrences  <= rgb_pkg::OCC_W'(occ);
    end
  end

endmodule

>>> sv/rectangular_grid_builder.sv
// Channel   Handshake               Contents
// input     in_valid / in_ready     operation, row fields, age_index, time_index
// output    out_valid / out_ready   status, counts, cell fields, occurrences
// config    selected_weight_id_we   selected_weight_id, written with no wait
//
// A clear, a load, an unused operation, a query with an index out of range or a query
// over an empty row store goes from S_EXEC to S_FINISH, which loads its result.
// A query with both indices in range over a nonempty row store walks the row store's
// single read port, one stored row a cycle, then passes S_DRAIN on its way to S_FINISH.
// Reset (rst, synchronous) empties both sorted sets and the row store and sets the
// selected weight id to zero. in_ready is high only while the block is idle, and a
// finished result waits for the output register, which holds one result for the receiver.
module rectangular_grid_builder #(
  parameter int MAX_AGES  = rgb_pkg::MAX_AGES_DEF,
  parameter int MAX_TIMES = rgb_pkg::MAX_TIMES_DEF,
  parameter int MAX_ROWS  = rgb_pkg::MAX_ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        selected_weight_id_we,
  input  logic [rgb_pkg::ID_W-1:0]    selected_weight_id,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  operation,
  input  logic [rgb_pkg::ID_W-1:0]    row_weight_id,
  input  logic [rgb_pkg::ID_W-1:0]    row_age_id,
  input  logic [rgb_pkg::ID_W-1:0]    row_time_id,
  input  logic [rgb_pkg::WGT_W-1:0]   row_weight,
  input  logic [rgb_pkg::IDX_W-1:0]   age_index,
  input  logic [rgb_pkg::IDX_W-1:0]   time_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [rgb_pkg::CNT_W-1:0]   age_count,
  output logic [rgb_pkg::CNT_W-1:0]   time_count,
  output logic [rgb_pkg::ID_W-1:0]    cell_age_id,
  output logic [rgb_pkg::ID_W-1:0]    cell_time_id,
  output logic [rgb_pkg::WGT_W-1:0]   cell_weight,
  output logic [rgb_pkg::OCC_W-1:0]   occurrences
);

  // The controller sequences each item; the datapath holds the sets,
  // the row store and the result register.
  rgb_pkg::cmd_t cmd;
  rgb_pkg::sts_t sts;

  rgb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  rgb_dp #(
    .MAX_AGES(MAX_AGES), .MAX_TIMES(MAX_TIMES), .MAX_ROWS(MAX_ROWS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .selected_weight_id_we(selected_weight_id_we),
    .selected_weight_id(selected_weight_id),
    .operation(operation), .row_weight_id(row_weight_id),
    .row_age_id(row_age_id), .row_time_id(row_time_id),
    .row_weight(row_weight), .age_index(age_index), .time_index(time_index),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .age_count(age_count), .time_count(time_count),
    .cell_age_id(cell_age_id), .cell_time_id(cell_time_id),
    .cell_weight(cell_weight), .occurrences(occurrences)
  );

endmodule
